// File: sv/jaci_pkg.sv
// shared constants and types for the joystick axis cursor integrator
`default_nettype none

package jaci_pkg;

    localparam logic [7:0] CENTER = 8'h80;
    localparam logic [7:0] STEP_DEFAULT = 8'd12;
    localparam logic [7:0] RAMP_THRESHOLD = 8'd12;
    localparam logic [3:0] RAMP_FRAMES = 4'd10;
    localparam logic [5:0] DZ_PCT_MAX = 6'd50;
    localparam int unsigned DIV_STEPS = 8;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_POS  = 2'd1,
        DIR_NEG  = 2'd2
    } t_dir;

    typedef enum logic [1:0] {
        REG_AXIS_MIN  = 2'd0,
        REG_AXIS_MAX  = 2'd1,
        REG_DZ_PCT    = 2'd2,
        REG_MAX_STEP  = 2'd3
    } t_reg_idx;

endpackage

`default_nettype wire

// File: sv/joystick_axis_cursor_integrator_core.sv
// top level: axis scaling, dead zone and accelerated cursor update
// One raw sample in, one result out. A sample passes from its request to its
// result through these steps: clamp and form the rounded numerator, eight
// steps in the restoring divider (one quotient bit per cycle), the dead zone
// test and direction tracking, two steps for the squared step product and one
// to update the cursor and load the output register. A centered sample skips
// the product steps; an empty range also skips the divider. The input is
// ready again the cycle after a result is loaded. A new sample is taken once
// the previous result sits in the output register, so a result that waits
// downstream stalls the next one only at the final step. Configuration
// writes are always taken and must only come while idle.
`default_nettype none

module joystick_axis_cursor_integrator_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] raw_sample
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [7:0] cursor_position, [15:8] normalized_axis
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NUM,
        ST_DIV,
        ST_DZ,
        ST_SQ,
        ST_MUL,
        ST_UPD
    } t_state;

    t_state r_state;

    logic [15:0] r_axis_min;
    logic [15:0] r_axis_max;
    logic [5:0]  r_dz_pct;
    logic [7:0]  r_max_step;

    logic [7:0]  r_cursor;
    jaci_pkg::t_dir r_held_dir;
    logic [3:0]  r_held_frames;

    logic [15:0] r_raw;
    logic [23:0] r_rem;
    logic [23:0] r_div;
    logic [2:0]  r_cnt;
    logic [7:0]  r_quot;
    logic [7:0]  r_norm;
    logic [7:0]  r_mag;
    logic        r_move;
    logic [15:0] r_sq;
    logic [7:0]  r_limit;
    logic [22:0] r_prod;

    logic        r_out_valid;
    logic [15:0] r_out_data;

    // clamp and numerator
    logic        range_empty;
    logic [15:0] range_w;
    logic [15:0] clamped;
    logic [15:0] diff;
    logic [23:0] numer;

    // divider step
    logic        div_ge;
    logic [23:0] div_sub;

    // dead zone
    logic [7:0]  deflect;
    logic [5:0]  pct;
    logic [14:0] deflect_x100;
    logic [14:0] dz_bound;
    logic        in_zone;
    jaci_pkg::t_dir new_dir;

    // step limit
    logic [4:0]  ramp;
    logic [7:0]  limit_w;

    // cursor update
    logic [22:0] prod_round;
    logic [7:0]  step;
    logic [8:0]  sum_pos;
    logic [7:0]  cur_next;
    logic        out_free;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign o_cfg_ready   = 1'b1;

    always_comb begin
        range_empty = (r_axis_max <= r_axis_min);
        range_w     = r_axis_max - r_axis_min;
        if (r_raw < r_axis_min) begin
            clamped = r_axis_min;
        end else if (r_raw > r_axis_max) begin
            clamped = r_axis_max;
        end else begin
            clamped = r_raw;
        end
        diff  = clamped - r_axis_min;
        numer = {diff, 8'd0} - {8'd0, diff} + {9'd0, range_w[15:1]};

        div_ge  = (r_rem >= r_div);
        div_sub = r_rem - r_div;

        deflect      = (r_quot >= jaci_pkg::CENTER) ? (r_quot - jaci_pkg::CENTER)
                                                    : (jaci_pkg::CENTER - r_quot);
        pct          = (r_dz_pct > jaci_pkg::DZ_PCT_MAX) ? jaci_pkg::DZ_PCT_MAX : r_dz_pct;
        deflect_x100 = {7'd0, deflect} * 15'd100;
        dz_bound     = {9'd0, pct} * 15'd255 + 15'd50;
        in_zone      = (deflect_x100 <= dz_bound);
        new_dir      = (r_quot < jaci_pkg::CENTER) ? jaci_pkg::DIR_NEG : jaci_pkg::DIR_POS;

        ramp = 5'd4 + {r_held_frames, 1'b0};
        if (r_max_step <= jaci_pkg::RAMP_THRESHOLD) begin
            limit_w = r_max_step;
        end else if ({3'd0, ramp} < r_max_step) begin
            limit_w = {3'd0, ramp};
        end else begin
            limit_w = r_max_step;
        end

        prod_round = r_prod + 23'd16383;
        step       = (prod_round[21:14] == 8'd0) ? 8'd1 : prod_round[21:14];
        sum_pos    = {1'b0, r_cursor} + {1'b0, step};
        if (!r_move) begin
            cur_next = r_cursor;
        end else if (r_held_dir == jaci_pkg::DIR_NEG) begin
            cur_next = (r_cursor > step) ? (r_cursor - step) : 8'd0;
        end else begin
            cur_next = sum_pos[8] ? 8'd255 : sum_pos[7:0];
        end

        out_free = !r_out_valid || m_axis_tready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_axis_min    <= 16'd0;
            r_axis_max    <= 16'hFFFF;
            r_dz_pct      <= 6'd12;
            r_max_step    <= jaci_pkg::STEP_DEFAULT;
            r_cursor      <= jaci_pkg::CENTER;
            r_held_dir    <= jaci_pkg::DIR_NONE;
            r_held_frames <= 4'd0;
            r_out_valid   <= 1'b0;
        end else begin
            if (r_out_valid && m_axis_tready && r_state != ST_UPD) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_valid) begin
                unique case (jaci_pkg::t_reg_idx'(i_cfg_index))
                    jaci_pkg::REG_AXIS_MIN: r_axis_min <= i_cfg_data;
                    jaci_pkg::REG_AXIS_MAX: r_axis_max <= i_cfg_data;
                    jaci_pkg::REG_DZ_PCT:   r_dz_pct   <= i_cfg_data[5:0];
                    jaci_pkg::REG_MAX_STEP: begin
                        r_max_step    <= (i_cfg_data[7:0] == 8'd0) ? jaci_pkg::STEP_DEFAULT
                                                                   : i_cfg_data[7:0];
                        r_held_dir    <= jaci_pkg::DIR_NONE;
                        r_held_frames <= 4'd0;
                    end
                    default: ;
                endcase
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_raw   <= s_axis_tdata;
                        r_state <= ST_NUM;
                    end
                end
                ST_NUM: begin
                    if (range_empty) begin
                        r_quot  <= jaci_pkg::CENTER;
                        r_state <= ST_DZ;
                    end else begin
                        r_rem   <= numer;
                        r_div   <= {1'b0, range_w, 7'd0};
                        r_cnt   <= 3'd0;
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_ge) begin
                        r_rem <= div_sub;
                    end
                    r_quot <= {r_quot[6:0], div_ge};
                    r_div  <= {1'b0, r_div[23:1]};
                    r_cnt  <= r_cnt + 3'd1;
                    if (r_cnt == 3'(jaci_pkg::DIV_STEPS - 1)) begin
                        r_state <= ST_DZ;
                    end
                end
                ST_DZ: begin
                    if (in_zone) begin
                        r_norm        <= jaci_pkg::CENTER;
                        r_move        <= 1'b0;
                        r_held_dir    <= jaci_pkg::DIR_NONE;
                        r_held_frames <= 4'd0;
                        r_state       <= ST_UPD;
                    end else begin
                        r_norm <= r_quot;
                        r_mag  <= deflect;
                        r_move <= 1'b1;
                        if (r_held_dir != new_dir) begin
                            r_held_dir    <= new_dir;
                            r_held_frames <= 4'd0;
                        end else if (r_held_frames < jaci_pkg::RAMP_FRAMES) begin
                            r_held_frames <= r_held_frames + 4'd1;
                        end
                        r_state <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    r_sq    <= {8'd0, r_mag} * {8'd0, r_mag};
                    r_limit <= limit_w;
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    r_prod  <= {8'd0, r_sq[14:0]} * {15'd0, r_limit};
                    r_state <= ST_UPD;
                end
                ST_UPD: begin
                    if (out_free) begin
                        r_cursor    <= cur_next;
                        r_out_data  <= {r_norm, cur_next};
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: sv/jaci_checker.sv
// port-level checks for the joystick axis cursor integrator
`default_nettype none

module jaci_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata
);

    // no result straight out of reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // a waiting result holds its data
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // busy after taking a sample
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after a request");

    // a new result only ends a busy period
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result without a sample in work");

endmodule

bind joystick_axis_cursor_integrator_core jaci_checker u_jaci_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// File: bench/tb_top.sv
// testbench for the joystick axis cursor integrator: directed, random and back-pressure runs
`timescale 1ns / 100ps

module tb_top;

    localparam int CLK_PERIOD = 10;
    localparam int RESET_CYCLES = 12;
    localparam int DRAIN_CYCLES = 20;
    localparam int QUIET_LIMIT = 3000;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int MAX_REPORTS = 10;
    localparam int unsigned STEP_SCALE = 16384;

    typedef struct packed {
        logic [7:0] axis;
        logic [7:0] cursor;
    } t_frame_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    // register copies
    logic [15:0] cfg_axis_min = 16'd0;
    logic [15:0] cfg_axis_max = 16'hFFFF;
    logic [5:0]  cfg_dz_pct = 6'd12;
    logic [7:0]  cfg_max_step = jaci_pkg::STEP_DEFAULT;

    // tracking copies
    logic [7:0]     cursor_pos = jaci_pkg::CENTER;
    jaci_pkg::t_dir held_dir = jaci_pkg::DIR_NONE;
    logic [3:0]     held_cnt = '0;

    t_frame_out  pending_frames[$];

    int src_idle_pct = 0;
    int sink_idle_pct = 0;
    int holdoff_req = 0;
    int holdoff_left = 0;
    int quiet_cycles = 0;

    int samples_sent = 0;
    int results_seen = 0;
    int reg_writes = 0;
    int mismatches = 0;
    int orphans = 0;
    int input_stall_cycles = 0;
    int centered_results = 0;
    int ramp_peak = 0;

    joystick_axis_cursor_integrator_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [15:0] raw_sample
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [7:0] cursor_position, [15:8] normalized_axis
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic logic [7:0] scale_axis(input logic [15:0] raw);
        int unsigned v, span, n, pct, dz, deflect;
        if (cfg_axis_max <= cfg_axis_min) return jaci_pkg::CENTER;
        v = raw;
        if (v < cfg_axis_min) v = cfg_axis_min;
        if (v > cfg_axis_max) v = cfg_axis_max;
        span = cfg_axis_max - cfg_axis_min;
        n = ((v - cfg_axis_min) * 255 + span / 2) / span;
        pct = (cfg_dz_pct > jaci_pkg::DZ_PCT_MAX) ? jaci_pkg::DZ_PCT_MAX : cfg_dz_pct;
        dz = (255 * pct + 50) / 100;
        deflect = (n >= jaci_pkg::CENTER) ? n - jaci_pkg::CENTER : jaci_pkg::CENTER - n;
        if (deflect <= dz) return jaci_pkg::CENTER;
        return n[7:0];
    endfunction

    function automatic t_frame_out advance_cursor(input logic [15:0] raw);
        logic [7:0] n;
        jaci_pkg::t_dir dir;
        int unsigned mag, lim, stepv, pos;
        n = scale_axis(raw);
        if (n == jaci_pkg::CENTER) begin
            held_dir = jaci_pkg::DIR_NONE;
            held_cnt = '0;
        end else begin
            if (n < jaci_pkg::CENTER) begin
                dir = jaci_pkg::DIR_NEG;
                mag = jaci_pkg::CENTER - n;
            end else begin
                dir = jaci_pkg::DIR_POS;
                mag = n - jaci_pkg::CENTER;
            end
            if (held_dir != dir) begin
                held_dir = dir;
                held_cnt = '0;
            end else if (held_cnt < jaci_pkg::RAMP_FRAMES) begin
                held_cnt++;
            end
            if (cfg_max_step <= jaci_pkg::RAMP_THRESHOLD) begin
                lim = cfg_max_step;
            end else begin
                lim = 4 + 2 * held_cnt;
                if (lim > cfg_max_step) lim = cfg_max_step;
            end
            stepv = (mag * mag * lim + STEP_SCALE - 1) / STEP_SCALE;
            if (stepv < 1) stepv = 1;
            if (dir == jaci_pkg::DIR_NEG) begin
                cursor_pos = (cursor_pos > stepv) ? 8'(cursor_pos - stepv) : 8'd0;
            end else begin
                pos = cursor_pos + stepv;
                cursor_pos = (pos > 255) ? 8'd255 : 8'(pos);
            end
            if (held_cnt > ramp_peak) ramp_peak = held_cnt;
        end
        return '{axis: n, cursor: cursor_pos};
    endfunction

    function automatic void check_frame(input logic [15:0] data);
        t_frame_out want;
        if (pending_frames.size() == 0) begin
            orphans++;
            $display("result %h arrived with no request pending", data);
            return;
        end
        want = pending_frames.pop_front();
        if (want.axis == jaci_pkg::CENTER) centered_results++;
        if (data[7:0] !== want.cursor || data[15:8] !== want.axis) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch on result %0d: cursor %0d axis %0d, expected cursor %0d axis %0d",
                         results_seen, data[7:0], data[15:8], want.cursor, want.axis);
        end
    endfunction

    // receiver: checks results and drives back-pressure
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            check_frame(m_axis_tdata);
            results_seen++;
        end
        if (i_rst_n && s_axis_tvalid && !s_axis_tready) input_stall_cycles++;
        if (holdoff_req > 0) begin
            holdoff_left = holdoff_req;
            holdoff_req = 0;
        end
        if (holdoff_left > 0) begin
            holdoff_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
            $display("tb_top failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_sample(input logic [15:0] raw);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= raw;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_frames.push_back(advance_cursor(raw));
        samples_sent++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input jaci_pkg::t_reg_idx idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            jaci_pkg::REG_AXIS_MIN: cfg_axis_min = data;
            jaci_pkg::REG_AXIS_MAX: cfg_axis_max = data;
            jaci_pkg::REG_DZ_PCT:   cfg_dz_pct = data[5:0];
            jaci_pkg::REG_MAX_STEP: begin
                cfg_max_step = (data[7:0] == 8'd0) ? jaci_pkg::STEP_DEFAULT : data[7:0];
                held_dir = jaci_pkg::DIR_NONE;
                held_cnt = '0;
            end
            default: ;
        endcase
        reg_writes++;
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_sample(input jaci_pkg::t_dir side);
        int unsigned span, lo, hi;
        if (cfg_axis_max <= cfg_axis_min || $urandom_range(19) == 0) return 16'($urandom);
        span = cfg_axis_max - cfg_axis_min;
        case (side)
            jaci_pkg::DIR_POS: begin
                lo = cfg_axis_min + span * 3 / 5;
                hi = ($urandom_range(9) == 0) ? 16'hFFFF : cfg_axis_max;
            end
            jaci_pkg::DIR_NEG: begin
                lo = ($urandom_range(9) == 0) ? 0 : cfg_axis_min;
                hi = cfg_axis_min + span * 2 / 5;
            end
            default: begin
                lo = cfg_axis_min + span * 9 / 20;
                hi = cfg_axis_min + span * 11 / 20;
            end
        endcase
        return 16'($urandom_range(hi, lo));
    endfunction

    task automatic randomize_config();
        logic [15:0] lo, hi, tmp;
        int unsigned pick, pct, stepv;
        if ($urandom_range(1)) begin
            pick = $urandom_range(9);
            lo = 16'($urandom);
            hi = 16'($urandom);
            if (pick < 4) begin
                lo = 16'd0;
                hi = 16'hFFFF;
            end else if (pick < 7) begin
                if (lo > hi) begin
                    tmp = lo;
                    lo = hi;
                    hi = tmp;
                end
            end else if (pick == 7) begin
                hi = (lo > 16'd65235) ? 16'hFFFF : lo + 16'($urandom_range(300, 1));
            end else if (pick == 8) begin
                hi = lo;
            end
            write_reg(jaci_pkg::REG_AXIS_MIN, lo);
            write_reg(jaci_pkg::REG_AXIS_MAX, hi);
        end
        if ($urandom_range(1)) begin
            case ($urandom_range(5))
                0: pct = 0;
                1: pct = $urandom_range(63);
                2: pct = ($urandom_range(1)) ? 50 : 63;
                default: pct = $urandom_range(20);
            endcase
            write_reg(jaci_pkg::REG_DZ_PCT, {10'($urandom), 6'(pct)});
        end
        if ($urandom_range(1)) begin
            case ($urandom_range(6))
                0: stepv = 0;
                1: stepv = 1;
                2: stepv = 12;
                3: stepv = 13;
                4: stepv = 255;
                default: stepv = $urandom_range(255);
            endcase
            write_reg(jaci_pkg::REG_MAX_STEP, {8'($urandom), 8'(stepv)});
        end
    endtask

    task automatic test_reset_defaults();
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        wait_idle();
    endtask

    task automatic test_range_limits();
        write_reg(jaci_pkg::REG_DZ_PCT, 16'hFFFF);
        send_sample(16'h0000);
        wait_idle();
        write_reg(jaci_pkg::REG_DZ_PCT, 16'd0);
        write_reg(jaci_pkg::REG_AXIS_MIN, 16'd1000);
        write_reg(jaci_pkg::REG_AXIS_MAX, 16'd2000);
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        send_sample(16'd1500);
        wait_idle();
        // empty range, equal then reversed bounds
        write_reg(jaci_pkg::REG_AXIS_MIN, 16'd5000);
        write_reg(jaci_pkg::REG_AXIS_MAX, 16'd5000);
        send_sample(16'd5000);
        wait_idle();
        write_reg(jaci_pkg::REG_AXIS_MIN, 16'd6000);
        send_sample(16'h0000);
        wait_idle();
        write_reg(jaci_pkg::REG_AXIS_MIN, 16'd0);
        write_reg(jaci_pkg::REG_AXIS_MAX, 16'hFFFF);
    endtask

    task automatic test_step_limits();
        write_reg(jaci_pkg::REG_MAX_STEP, 16'h0000);
        send_sample(16'hFFFF);
        wait_idle();
        write_reg(jaci_pkg::REG_MAX_STEP, 16'd1);
        send_sample(16'd33100);
        wait_idle();
        // full ramp held in one direction, then a reversal
        write_reg(jaci_pkg::REG_MAX_STEP, 16'd255);
        repeat (11) send_sample(16'd16448);
        send_sample(16'd49087);
        wait_idle();
        write_reg(jaci_pkg::REG_MAX_STEP, 16'd13);
        send_sample(16'd49087);
        wait_idle();
    endtask

    task automatic test_random_traffic(input int src_pct, input int snk_pct, input int items);
        int done, seg, kind, run_len;
        jaci_pkg::t_dir side;
        src_idle_pct = src_pct;
        sink_idle_pct = snk_pct;
        done = 0;
        while (done < items) begin
            wait_idle();
            randomize_config();
            seg = $urandom_range(120, 20);
            while (seg > 0) begin
                kind = $urandom_range(99);
                if (kind < 60) begin
                    side = ($urandom_range(1)) ? jaci_pkg::DIR_POS : jaci_pkg::DIR_NEG;
                    run_len = $urandom_range(14, 1);
                end else if (kind < 80) begin
                    side = jaci_pkg::DIR_NONE;
                    run_len = $urandom_range(3, 1);
                end else begin
                    side = jaci_pkg::DIR_NONE;
                    run_len = $urandom_range(4, 1);
                end
                repeat (run_len) send_sample((kind < 80) ? pick_sample(side) : 16'($urandom));
                seg -= run_len;
                done += run_len;
            end
        end
        wait_idle();
    endtask

    task automatic test_output_backpressure();
        src_idle_pct = 0;
        sink_idle_pct = 0;
        holdoff_req = HOLDOFF_CYCLES;
        repeat (40) begin
            send_sample(pick_sample(($urandom_range(1)) ? jaci_pkg::DIR_POS
                                                        : jaci_pkg::DIR_NEG));
        end
        wait_idle();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        src_idle_pct = 29;
        sink_idle_pct = 45;
        test_reset_defaults();
        test_range_limits();
        test_step_limits();
        test_random_traffic(29, 45, 520);
        test_random_traffic(45, 29, 520);
        test_random_traffic(0, 0, 520);
        test_output_backpressure();
        wait_idle();
        $display("covered %0d samples and %0d results over %0d register writes, %0d centered",
                 samples_sent, results_seen, reg_writes, centered_results);
        $display("ramp reached frame %0d, input stalled %0d cycles, %0d mismatches, %0d orphans",
                 ramp_peak, input_stall_cycles, mismatches, orphans);
        if (mismatches == 0 && orphans == 0 && pending_frames.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
